/* sv/pta_pkg.sv */
// ---------------------------------------------------------------------------
// Partition transfer accounting package
// Shared types and constants for the accounting block.
// ---------------------------------------------------------------------------
package pta_pkg;

    localparam int MAX_PARTITIONS_DEF = 8;
    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 200;
    localparam int M_TUSER_W = 2;
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        MODE_XFER  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] start_block;
        logic [12:0] block_size;
        logic [31:0] byte_count;
        logic        is_write;
        logic [7:0]  part_id;
        logic [31:0] part_first_block;
        logic [31:0] part_block_count;
        logic [2:0]  query_index;
    } item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] first_block;
        logic [31:0] end_block;
        logic [31:0] written;
        logic [31:0] read;
    } slot_t;

    typedef struct packed {
        logic        status;
        logic        entry_valid;
        logic [7:0]  entry_id;
        logic [31:0] entry_first_block;
        logic [31:0] entry_end_block;
        logic [31:0] entry_written_bytes;
        logic [31:0] entry_read_bytes;
        logic [31:0] total_written_bytes;
        logic [31:0] total_read_bytes;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_CMP,
        ST_MUL,
        ST_WR,
        ST_QRY,
        ST_DONE
    } state_t;

endpackage

/* sv/partition_transfer_accounting.sv */
// Query, add and clear touch at most one table slot; a transfer first runs the
// 32-step divider and then walks the table slots.
// The back end takes one request at a time and finishes its result before the next.
// A two-entry input queue keeps accepting while a result waits, until it is full.
// Reset (aresetn low, synchronous) empties the table and zeroes the device totals.
// ---------------------------------------------------------------------------
// Partition transfer accounting
// Per-partition and device byte counters fed by block transfers.
// ---------------------------------------------------------------------------
module partition_transfer_accounting
    import pta_pkg::*;
#(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_block, block_size, byte_count, part_id, part_first_block,
    // part_block_count, query_index
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode, is_write
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry_id, entry_first_block, entry_end_block, entry_written_bytes,
    // entry_read_bytes, total_written_bytes, total_read_bytes
    output logic [M_TDATA_W-1:0] m_tdata,
    // status, entry_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic    head_valid;
    item_t   head;
    logic    head_pop;
    result_t res;

    pta_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    pta_back #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tuser = {res.entry_valid, res.status};
    assign m_tdata = {res.total_read_bytes, res.total_written_bytes,
                      res.entry_read_bytes, res.entry_written_bytes,
                      res.entry_end_block, res.entry_first_block, res.entry_id};

endmodule

/* sv/pta_front.sv */
// ---------------------------------------------------------------------------
// Partition transfer accounting front end
// Unpacks incoming requests and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module pta_front
    import pta_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 head_valid,
    output item_t                head,
    input  logic                 head_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    always_comb begin
        in_item.mode             = mode_t'(s_tuser[1:0]);
        in_item.is_write         = s_tuser[2];
        in_item.start_block      = s_tdata[31:0];
        in_item.block_size       = s_tdata[44:32];
        in_item.byte_count       = s_tdata[76:45];
        in_item.part_id          = s_tdata[84:77];
        in_item.part_first_block = s_tdata[116:85];
        in_item.part_block_count = s_tdata[148:117];
        in_item.query_index      = s_tdata[151:149];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (head_pop && head_valid);
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, head_pop && head_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* sv/pta_back.sv */
// ---------------------------------------------------------------------------
// Partition transfer accounting back end
// Runs the division, walks the partition table and builds each result.
// ---------------------------------------------------------------------------
module pta_back
    import pta_pkg::*;
#(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  item_t   head,
    output logic    head_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    slot_t mem [MAX_PARTITIONS];
    slot_t rdata_reg;

    state_t      state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] dev_w_reg, dev_w_next;
    logic [31:0] dev_r_reg, dev_r_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [13:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] prod_reg, prod_next;
    result_t     res_reg, res_next;
    logic        res_valid_reg, res_valid_next;

    logic        we;
    logic [IDX_W-1:0] wr_addr;
    slot_t       wdata;
    logic [13:0] rem_sh;
    logic [31:0] clip_end;
    logic        q_ok;

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        dev_w_next     = dev_w_reg;
        dev_r_next     = dev_r_reg;
        idx_next       = idx_reg;
        rd_addr_next   = rd_addr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        end_next       = end_reg;
        span_next      = span_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        head_pop       = 1'b0;
        we             = 1'b0;
        wr_addr        = idx_reg;
        wdata          = rdata_reg;
        rem_sh         = {rem_reg[12:0], quo_reg[31]};
        clip_end       = (end_reg > rdata_reg.end_block) ? rdata_reg.end_block : end_reg;
        q_ok           = CMP_W'(cur_reg.query_index) < CMP_W'(cnt_reg);

        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    head_pop = 1'b1;
                    cur_next = head;
                    res_next = '0;
                    case (head.mode)
                        MODE_XFER: begin
                            if (head.is_write) begin
                                dev_w_next = dev_w_reg + head.byte_count;
                            end else begin
                                dev_r_next = dev_r_reg + head.byte_count;
                            end
                            rem_next   = '0;
                            quo_next   = head.byte_count;
                            step_next  = '0;
                            state_next = ST_DIV;
                        end
                        MODE_ADD: begin
                            if (cnt_reg == CNT_W'(MAX_PARTITIONS)) begin
                                res_next.status = 1'b1;
                            end else begin
                                we                = 1'b1;
                                wr_addr           = IDX_W'(cnt_reg);
                                wdata.id          = head.part_id;
                                wdata.first_block = head.part_first_block;
                                wdata.end_block   = head.part_first_block
                                                    + head.part_block_count;
                                wdata.written     = '0;
                                wdata.read        = '0;
                                cnt_next          = cnt_reg + 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        MODE_CLEAR: begin
                            cnt_next   = '0;
                            dev_w_next = '0;
                            dev_r_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            rd_addr_next = IDX_W'(head.query_index);
                            state_next   = ST_QRY;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // One restoring step per cycle; a zero divisor leaves the quotient at zero.
                if (cur_reg.block_size != '0 && rem_sh >= {1'b0, cur_reg.block_size}) begin
                    rem_next = rem_sh - {1'b0, cur_reg.block_size};
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 6'(DIV_STEPS - 1)) begin
                    end_next = cur_reg.start_block
                               + ((cur_reg.block_size != '0) ? quo_next : 32'd0);
                    if (cnt_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next     = IDX_W'(cnt_reg - 1'b1);
                        rd_addr_next = IDX_W'(cnt_reg - 1'b1);
                        state_next   = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cur_reg.start_block >= rdata_reg.end_block) begin
                    state_next = ST_DONE;
                end else if (end_reg <= rdata_reg.first_block) begin
                    if (idx_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next     = idx_reg - 1'b1;
                        rd_addr_next = idx_reg - 1'b1;
                        state_next   = ST_RD;
                    end
                end else begin
                    if (rdata_reg.first_block <= cur_reg.start_block) begin
                        span_next = clip_end - cur_reg.start_block;
                        end_next  = cur_reg.start_block;
                    end else begin
                        span_next = clip_end - rdata_reg.first_block;
                        end_next  = rdata_reg.first_block;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = 32'(span_reg * {19'd0, cur_reg.block_size});
                state_next = ST_WR;
            end
            ST_WR: begin
                we = 1'b1;
                if (cur_reg.is_write) begin
                    wdata.written = rdata_reg.written + prod_reg;
                end else begin
                    wdata.read = rdata_reg.read + prod_reg;
                end
                if (end_reg == cur_reg.start_block || idx_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next     = idx_reg - 1'b1;
                    rd_addr_next = idx_reg - 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_QRY: begin
                // The read address was loaded on entry, so the slot is in rdata_reg now.
                if (q_ok) begin
                    res_next.entry_valid         = 1'b1;
                    res_next.entry_id            = rdata_reg.id;
                    res_next.entry_first_block   = rdata_reg.first_block;
                    res_next.entry_end_block     = rdata_reg.end_block;
                    res_next.entry_written_bytes = rdata_reg.written;
                    res_next.entry_read_bytes    = rdata_reg.read;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_next.total_written_bytes = dev_w_reg;
                res_next.total_read_bytes    = dev_r_reg;
                if (!res_valid_reg) begin
                    res_valid_next = 1'b1;
                end else if (res_ready) begin
                    res_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            dev_w_reg     <= '0;
            dev_r_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dev_w_reg     <= dev_w_next;
            dev_r_reg     <= dev_r_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        rd_addr_reg <= rd_addr_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        end_reg     <= end_next;
        span_reg    <= span_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wdata;
        end
        rdata_reg <= mem[rd_addr_next];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PARTITIONS))
        else $error("partition count above table size");

    a_res_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> state_reg == ST_DONE)
        else $error("result valid outside completion state");

    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> CMP_W'(idx_reg) < CMP_W'(cnt_reg))
        else $error("table walk beyond filled slots");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> state_reg == ST_IDLE)
        else $error("request taken while busy");

endmodule
